// ===== rtl/rational_normalizer_assert.svh =====
// Assertion macros used by the checker file of the rational normalizer.
`ifndef RATIONAL_NORMALIZER_ASSERT_SVH
`define RATIONAL_NORMALIZER_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold as well.
`define RN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication: whenever ante holds, cons must hold in the following cycle.
`define RN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rn_pkg.sv =====
// Package with widths, command and status types and helpers of the rational normalizer.
package rn_pkg;

  localparam int DataWidth = 32;
  localparam int MagWidth  = DataWidth - 1;
  localparam int CntWidth  = $clog2(MagWidth);
  localparam int DivSteps  = MagWidth;
  localparam int InTdataW  = ((2 * DataWidth + 7) / 8) * 8;
  localparam int OutTdataW = ((DataWidth + MagWidth + 7) / 8) * 8;
  localparam int OutTuserW = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_REDUCE,
    ST_DIVIDE,
    ST_FINISH
  } rn_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic strip;
    logic reduce;
    logic div_init;
    logic div_step;
    logic out_load;
  } rn_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic special;
    logic both_even;
    logic gcd_done;
  } rn_status_t;

  // Magnitude of a two's complement word, with the most negative value
  // saturated to the largest positive magnitude.
  function automatic logic [MagWidth-1:0] sat_mag(input logic [DataWidth-1:0] v);
    logic [DataWidth-1:0] abs_v;
    abs_v = v[DataWidth-1] ? (~v + DataWidth'(1)) : v;
    if (abs_v[DataWidth-1]) begin
      return '1;
    end
    return abs_v[MagWidth-1:0];
  endfunction

endpackage

// ===== rtl/rational_normalizer.sv =====
// Top level of the rational normalizer: reduces a signed fraction to lowest terms.
// Usage:
// One request on the slave stream carries a signed numerator and a signed
// denominator. The block moves the sign onto the numerator, divides both
// magnitudes by their greatest common divisor and sends one request on the
// master stream with the reduced fraction and finite, NaN and zero flags.
// A zero denominator yields +1/0, -1/0 or 0/0 (NaN); a zero numerator
// yields 0/1. The most negative input value is saturated by one.
// Sequencing: one request is worked on at a time. Zero cases go from
// acceptance through the strip state straight to the finish state. Other
// requests pass through loading, the binary GCD loop (common factors of
// two stripped, then one factor of two removed per step) and then the
// bit-serial divider, one quotient bit per step, before the finish state.
// A finished result sits in an output register, so a new request is
// accepted while the previous result waits for the receiver. When the
// receiver stalls, the result holds steady and the next one waits inside.
// Reset clears the state machine and the output valid flag at once; no
// request is pending afterwards.
module rational_normalizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: [31:0] numerator_in, [63:32] denominator_in
  input  logic [rn_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: [31:0] numerator_out, [62:32] denominator_out, [63] zero fill
  output logic [rn_pkg::OutTdataW-1:0]  m_axis_tdata,
  // tuser: [0] is_finite, [1] is_nan, [2] is_zero
  output logic [rn_pkg::OutTuserW-1:0]  m_axis_tuser
);
  import rn_pkg::*;

  rn_cmd_t    cmd;
  rn_status_t status;

  // The controller sequences the load, GCD, division and output steps.
  rn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds all operands and the result register.
  rn_datapath u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

endmodule

// ===== rtl/rn_datapath.sv =====
// Datapath of the rational normalizer: operand registers, binary GCD, dividers, result register.
module rn_datapath (
  input  logic                          clk_i,
  input  rn_pkg::rn_cmd_t               cmd_i,
  output rn_pkg::rn_status_t            status_o,
  input  logic [rn_pkg::InTdataW-1:0]   in_data_i,
  output logic [rn_pkg::OutTdataW-1:0]  out_data_o,
  output logic [rn_pkg::OutTuserW-1:0]  out_user_o
);
  import rn_pkg::*;

  logic [DataWidth-1:0] num_raw, den_raw;
  logic [MagWidth-1:0]  nmag_q, dmag_q;
  logic                 neg_q;
  logic [MagWidth-1:0]  a_q, a_d, b_q, b_d;
  logic [CntWidth-1:0]  k_q, k_d;
  logic [MagWidth-1:0]  g_q;
  logic [MagWidth-1:0]  rem_n_q, rem_d_q, quo_n_q, quo_d_q;
  logic [MagWidth:0]    sh_n, sh_d;
  logic                 ge_n, ge_d;
  logic [MagWidth-1:0]  a_minus_b, b_minus_a;
  logic [MagWidth-1:0]  rn, rd;
  logic [DataWidth-1:0] num_field;
  logic [DataWidth-1:0] out_num_q;
  logic [MagWidth-1:0]  out_den_q;
  logic                 out_fin_q, out_nan_q, out_zero_q;
  logic                 n_zero, d_zero;

  assign num_raw = in_data_i[DataWidth-1:0];
  assign den_raw = in_data_i[2*DataWidth-1:DataWidth];

  assign n_zero = (nmag_q == '0);
  assign d_zero = (dmag_q == '0);

  assign status_o.special   = n_zero | d_zero;
  assign status_o.both_even = ~a_q[0] & ~b_q[0];
  assign status_o.gcd_done  = (a_q == b_q);

  assign a_minus_b = a_q - b_q;
  assign b_minus_a = b_q - a_q;

  // Binary GCD: strip common factors of two, then shift out single factors
  // of two or replace the larger odd operand by half the difference.
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (cmd_i.load) begin
      a_d = sat_mag(num_raw);
      b_d = sat_mag(den_raw);
      k_d = '0;
    end else if (cmd_i.strip) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
      k_d = k_q + CntWidth'(1);
    end else if (cmd_i.reduce) begin
      if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q > b_q) begin
        a_d = a_minus_b >> 1;
      end else begin
        b_d = b_minus_a >> 1;
      end
    end
  end

  // Restoring division of both magnitudes by the common divisor, one
  // quotient bit per cycle and operand.
  assign sh_n = {rem_n_q, quo_n_q[MagWidth-1]};
  assign sh_d = {rem_d_q, quo_d_q[MagWidth-1]};
  assign ge_n = (sh_n >= {1'b0, g_q});
  assign ge_d = (sh_d >= {1'b0, g_q});

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
    if (cmd_i.load) begin
      nmag_q <= sat_mag(num_raw);
      dmag_q <= sat_mag(den_raw);
      neg_q  <= (num_raw[DataWidth-1] != den_raw[DataWidth-1]) && (num_raw != '0);
    end
    if (cmd_i.div_init) begin
      g_q     <= a_q << k_q;
      rem_n_q <= '0;
      rem_d_q <= '0;
      quo_n_q <= nmag_q;
      quo_d_q <= dmag_q;
    end else if (cmd_i.div_step) begin
      rem_n_q <= ge_n ? MagWidth'(sh_n - {1'b0, g_q}) : sh_n[MagWidth-1:0];
      rem_d_q <= ge_d ? MagWidth'(sh_d - {1'b0, g_q}) : sh_d[MagWidth-1:0];
      quo_n_q <= {quo_n_q[MagWidth-2:0], ge_n};
      quo_d_q <= {quo_d_q[MagWidth-2:0], ge_d};
    end
  end

  // A zero denominator gives a signed unit over zero, or NaN; a zero
  // numerator gives zero over one.
  always_comb begin
    if (d_zero) begin
      rn = n_zero ? '0 : MagWidth'(1);
      rd = '0;
    end else if (n_zero) begin
      rn = '0;
      rd = MagWidth'(1);
    end else begin
      rn = quo_n_q;
      rd = quo_d_q;
    end
    num_field = neg_q ? (~{1'b0, rn} + DataWidth'(1)) : {1'b0, rn};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_num_q  <= num_field;
      out_den_q  <= rd;
      out_fin_q  <= (rd != '0);
      out_nan_q  <= (rn == '0) && (rd == '0);
      out_zero_q <= (rn == '0) && (rd != '0);
    end
  end

  assign out_data_o = OutTdataW'({out_den_q, out_num_q});
  assign out_user_o = {out_zero_q, out_nan_q, out_fin_q};

endmodule

// ===== rtl/rn_ctrl.sv =====
// Controller of the rational normalizer: sequencing state machine and output valid flag.
module rn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rn_pkg::rn_status_t status_i,
  output rn_pkg::rn_cmd_t    cmd_o
);
  import rn_pkg::*;

  rn_state_e           state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (status_i.special) begin
          state_d = ST_FINISH;
        end else if (status_i.both_even) begin
          cmd_o.strip = 1'b1;
        end else begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = ST_DIVIDE;
        end else begin
          cmd_o.reduce = 1'b1;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(DivSteps - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/rn_checker.sv =====
// Port-level checker of the rational normalizer and its bind to the top level.
`include "rational_normalizer_assert.svh"

module rn_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rn_pkg::OutTdataW-1:0]  m_axis_tdata,
  input logic [rn_pkg::OutTuserW-1:0]  m_axis_tuser
);
  import rn_pkg::*;

  logic [DataWidth-1:0] out_num;
  logic [MagWidth-1:0]  out_den;

  assign out_num = m_axis_tdata[DataWidth-1:0];
  assign out_den = m_axis_tdata[DataWidth+MagWidth-1:DataWidth];

  // A stalled result keeps its value.
  `RN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // After a request is accepted the block is not ready in the following cycle.
  `RN_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                  !s_axis_tready)

  // The finite flag matches a nonzero denominator.
  `RN_ASSERT_IMPLY(a_finite_flag, clk_i, rst_ni, m_axis_tvalid,
                   m_axis_tuser[0] == (out_den != '0))

  // NaN and zero flags match the fraction they describe.
  `RN_ASSERT_IMPLY(a_nan_zero_flags, clk_i, rst_ni, m_axis_tvalid,
                   (m_axis_tuser[1] == ((out_num == '0) && (out_den == '0))) &&
                   (m_axis_tuser[2] == ((out_num == '0) && (out_den != '0))))

endmodule

bind rational_normalizer rn_checker u_rn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
